@@ sv/signed_int_to_decimal_ascii_defines.svh @@
// assertion macros shared by the decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// checked on every clock edge outside reset
`define SIDA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define SIDA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ sv/sida_pkg.sv @@
// shared constants and types for the decimal text converter
`default_nettype none

package sida_pkg;

   localparam int MAX_DIGITS    = 10;
   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 7;
   localparam int RSP_TDATA_W   = 8;
   localparam int DIGIT_W       = 4;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int CONV_CNT_W    = $clog2(CONV_STEPS);
   localparam int POS_W         = $clog2(MAX_DIGITS);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'd57;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
   localparam logic [DIGIT_W-1:0] ADJ_THRESH = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ sv/sida_digit_cell.sv @@
// one decimal digit cell: shift-add-3 conversion and digit shift chain
`default_nettype none

module sida_digit_cell
   import sida_pkg::*;
(
   input  wire logic                     clock,
   input  wire cell_ctl_type             ctl,
   input  wire logic [BITS_PER_STEP-1:0] carry_in,
   output logic      [BITS_PER_STEP-1:0] carry_out,
   input  wire logic [DIGIT_W-1:0]       digit_below,
   output logic      [DIGIT_W-1:0]       digit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] conv_digit;

   // several doubling steps per cycle, first carry bit is the most significant
   always_comb begin
      logic [DIGIT_W-1:0] d;
      logic [DIGIT_W-1:0] adj;
      d = digit_ff;
      adj = '0;
      carry_out = '0;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         adj = (d >= ADJ_THRESH) ? d + ADJ_ADD : d;
         carry_out[j] = adj[DIGIT_W-1];
         d = {adj[DIGIT_W-2:0], carry_in[j]};
      end
      conv_digit = d;
   end

   always_comb begin
      if (ctl.load) begin
         digit_in = '0;
      end else if (ctl.conv) begin
         digit_in = conv_digit;
      end else if (ctl.shift) begin
         digit_in = digit_below;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule

`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// Converts a 32-bit two's complement integer into its decimal text, one
// ASCII character per response, most significant digit first, with a
// leading '-' for negative values, no leading zeros and tlast on the final
// character; the most negative value reads -2147483648. A request is taken
// only while the converter is idle. A row of ten digit cells runs a
// shift-add-3 conversion that takes four bits of the magnitude per cycle,
// then shifts the digits out of the top cell one per cycle while the sink
// takes them, skipping leading zeros without a response; a stalled sink
// holds the digit shift.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
   import sida_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [VALUE_W-1:0]     req_tdata,   // [31:0] value
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic                        rsp_tlast    // last_char
);

   state_type                state_ff, state_in;
   logic [VALUE_W-1:0]       mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [CONV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     started_ff, started_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctl_type             cell_ctl;
   logic [BITS_PER_STEP-1:0] carry [MAX_DIGITS+1];
   logic [DIGIT_W-1:0]       digit [MAX_DIGITS];

   logic               req_fire;
   logic               out_free;
   logic               emit_step;
   logic               last_step;
   logic               is_last;
   logic               digit_shown;
   logic [DIGIT_W-1:0] top_digit;
   logic               conv_overflow;
   logic               rsp_minus;
   logic               rsp_digit;

   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign emit_step   = (state_ff == ST_EMIT) && out_free;
   assign is_last     = (pos_ff == POS_W'(MAX_DIGITS - 1));
   assign last_step   = emit_step && !neg_ff && is_last;
   assign top_digit   = digit[MAX_DIGITS-1];
   assign digit_shown = started_ff || (top_digit != '0) || is_last;

   // magnitude bits enter the bottom cell, most significant first
   for (genvar j = 0; j < BITS_PER_STEP; j++) begin : g_feed
      assign carry[0][j] = mag_ff[VALUE_W-1-j];
   end

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      logic [DIGIT_W-1:0] below;
      if (i == 0) begin : g_bottom
         assign below = '0;
      end else begin : g_upper
         assign below = digit[i-1];
      end
      sida_digit_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .carry_in    (carry[i]),
         .carry_out   (carry[i+1]),
         .digit_below (below),
         .digit_out   (digit[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (cnt_ff == CONV_CNT_W'(CONV_STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (last_step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      cell_ctl.load  = req_fire;
      cell_ctl.conv  = (state_ff == ST_CONV);
      cell_ctl.shift = emit_step && !neg_ff;

      mag_in     = mag_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      started_in = started_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_fire) begin
         mag_in     = req_tdata[VALUE_W-1] ? (VALUE_W'(0) - req_tdata) : req_tdata;
         neg_in     = req_tdata[VALUE_W-1];
         cnt_in     = '0;
         pos_in     = '0;
         started_in = 1'b0;
      end else if (cell_ctl.conv) begin
         mag_in = mag_ff << BITS_PER_STEP;
         cnt_in = cnt_ff + CONV_CNT_W'(1);
      end

      if (emit_step) begin
         if (neg_ff) begin
            neg_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_MINUS;
            rsp_last_in  = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (digit_shown) begin
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_W'(top_digit);
               rsp_last_in  = is_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - CHAR_W)'(0), rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign conv_overflow = cell_ctl.conv && (carry[MAX_DIGITS] != '0);
   assign rsp_minus     = rsp_tvalid && (rsp_char_ff == CHAR_MINUS);
   assign rsp_digit     = (rsp_char_ff >= CHAR_ZERO) && (rsp_char_ff <= CHAR_NINE);

   // ten digits always hold a 32-bit magnitude
   `SIDA_ASSERT(a_no_digit_overflow, !conv_overflow, "digit chain overflow")

   `SIDA_ASSERT(a_char_legal, rsp_tvalid |-> (rsp_minus || rsp_digit), "illegal character code")

   `SIDA_ASSERT(a_last_flagged, last_step |=> (rsp_tvalid && rsp_tlast), "final digit not flagged")

   `SIDA_ASSERT(a_minus_not_last, rsp_minus |-> !rsp_tlast, "minus sign flagged as last")

   `SIDA_ASSERT_RST(a_reset_idle, reset |=> (req_tready && !rsp_tvalid), "not idle after reset")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the signed integer to decimal text converter
module testbench;
   import sida_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 350;
   localparam int HOLD_CYCLES    = 300;
   localparam int TEXT_BYTES     = MAX_DIGITS + 1;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } ascii_char_type;

   // text left empty means the row is checked against the predictor
   typedef struct packed {
      logic [VALUE_W-1:0]      value;
      logic [8*TEXT_BYTES-1:0] text;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{32'd0,           "0"},
      '{32'd1,           "1"},
      '{-32'sd1,         "-1"},
      '{32'd9,           "9"},
      '{32'd10,          "10"},
      '{-32'sd9,         "-9"},
      '{-32'sd10,        "-10"},
      '{32'h7FFF_FFFF,   "2147483647"},
      '{32'h8000_0000,   "-2147483648"},
      '{32'h8000_0001,   "-2147483647"},
      '{32'd1000000000,  "1000000000"},
      '{32'd1234567890,  "1234567890"},
      '{32'd999999999,   ""},
      '{-32'sd1000000000, ""},
      '{-32'sd1234567890, ""},
      '{32'h5555_5555,   ""},
      '{32'hAAAA_AAAA,   ""},
      '{32'd100,         ""},
      '{32'd4095,        ""},
      '{-32'sd65536,     ""}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata;   // [31:0] value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [6:0] char_code, [7] zero
   logic                   rsp_tlast;   // last_char

   ascii_char_type pending_chars [$];
   int             error_count = 0;
   int             requests_sent = 0;
   int             idle_cycles = 0;
   logic           calm = 1'b0;
   logic           hold = 1'b0;

   signed_int_to_decimal_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic void queue_char(input logic [CHAR_W-1:0] code, input logic last);
      ascii_char_type c;
      c.code = code;
      c.last = last;
      pending_chars.push_back(c);
   endfunction

   // queues the decimal text of one value, sign first, most significant digit first
   function automatic void decimal_text_of(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] magnitude;
      logic [3:0]         digits [MAX_DIGITS];
      int                 count;
      count = 0;
      if (value == '0) begin
         queue_char(CHAR_ZERO, 1'b1);
         return;
      end
      magnitude = value[VALUE_W-1] ? -value : value;
      if (value[VALUE_W-1]) begin
         queue_char(CHAR_MINUS, 1'b0);
      end
      while (magnitude != 0 && count < MAX_DIGITS) begin
         digits[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         queue_char(CHAR_ZERO + CHAR_W'(digits[k]), k == 0);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] power_of_ten(input int exponent);
      logic [VALUE_W-1:0] p;
      p = 1;
      repeat (exponent) p = p * 10;
      return p;
   endfunction

   // half the values stress digit count, sign and the range ends, the rest are random
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      int                 kind;
      kind = $urandom_range(0, 9);
      case (kind)
         3: begin
            v = $urandom_range(0, 40) - 20;
         end
         4, 5: begin
            v = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         6: begin
            if ($urandom_range(0, 1)) v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            else v = 32'h8000_0000 + $urandom_range(0, 3);
         end
         7: begin
            v = $urandom % power_of_ten($urandom_range(1, 9));
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   task automatic send_request(input logic [VALUE_W-1:0] value,
                               input logic [8*TEXT_BYTES-1:0] text);
      logic typed;
      typed = 1'b0;
      while (!calm && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      // typed text is right-justified, so the final character sits in byte zero
      for (int b = TEXT_BYTES - 1; b >= 0; b--) begin
         if (text[8*b +: 8] != 8'd0) begin
            queue_char(text[8*b +: CHAR_W], b == 0);
            typed = 1'b1;
         end
      end
      if (!typed) decimal_text_of(value);
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      ascii_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch("unexpected character", -1, rsp_tdata[CHAR_W-1:0]);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.code)
                  report_mismatch("char_code", want.code, rsp_tdata[CHAR_W-1:0]);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_char", want.last, rsp_tlast);
            end
         end
         rsp_tready <= hold ? 1'b0 : (calm || $urandom_range(0, 99) >= 10);
      end
   end

   // long sink stall so the converter backs up onto the request side
   initial begin
      while (requests_sent < 80) @(posedge clock);
      hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(DIRECTED_TABLE[i].value, DIRECTED_TABLE[i].text);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= 150 && n < 250);
         send_request(random_value(), '0);
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
